### rtl/busy_permille_load_sampler_macros.svh
// Assertion macros used by the load sampler checker.
`ifndef BUSY_PERMILLE_LOAD_SAMPLER_MACROS_SVH
`define BUSY_PERMILLE_LOAD_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPLS_ASSERT_NOW(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BPLS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bpls_pkg.sv
// Types and constants of the busy permille load sampler.
`default_nettype none

package bpls_pkg;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  entry_index;
        logic [63:0] thread_cycles;
        logic [31:0] core_cycles;
    } bpls_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] total_cycles;
        logic [31:0] work_cycles;
        logic [9:0]  busy_permille;
    } bpls_out_t;

    typedef struct packed {
        logic        enabled;
        logic [4:0]  entry_count;
        logic [23:0] bg_mask;
    } bpls_cfg_t;

    localparam logic REQ_THREAD = 1'b0;
    localparam logic REQ_END    = 1'b1;

    localparam logic [1:0] STAT_VALID       = 2'd0;
    localparam logic [1:0] STAT_PRIMED      = 2'd1;
    localparam logic [1:0] STAT_NOT_STARTED = 2'd2;

    localparam logic [1:0] CFG_ENABLED     = 2'd0;
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd1;
    localparam logic [1:0] CFG_BG_MASK     = 2'd2;

    localparam int BG_MASK_BITS = 24;
    localparam int PERMILLE     = 1000;
    localparam int QUOT_BITS    = 10;
    localparam int DIV_W        = 42;   // 32-bit work times 1000
    localparam int CNT_W        = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_PRIME,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_EMIT_OFF,
        ST_EMIT_PRIMED,
        ST_EMIT_SAMPLE
    } bpls_state_t;

    typedef struct packed {
        logic       capture;
        logic       update;
        logic       accum;
        logic       prime;
        logic       calc;
        logic       mul;
        logic       div_step;
        logic       emit;
        logic [1:0] emit_status;
    } bpls_cmd_t;

    typedef struct packed {
        logic thread_ok;
        logic enabled;
        logic primed;
        logic div_done;
        logic out_free;
    } bpls_stat_t;

endpackage

`default_nettype wire

### rtl/bpls_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none

module bpls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 24,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/bpls_ctrl.sv
// Sequencer of the load sampler: steps the datapath through one request.
`default_nettype none

module bpls_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_req,
    input  wire bpls_pkg::bpls_stat_t stat,
    output logic                     in_stall,
    output bpls_pkg::bpls_cmd_t      cmd
);
    import bpls_pkg::*;

    bpls_state_t state_reg;
    bpls_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req == REQ_THREAD)
                    begin
                        state_next = stat.thread_ok ? ST_READ : ST_IDLE;
                    end
                    else if (!stat.enabled)
                    begin
                        state_next = ST_EMIT_OFF;
                    end
                    else if (!stat.primed)
                    begin
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_READ:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_IDLE;
            ST_PRIME: state_next = ST_EMIT_PRIMED;
            ST_CALC:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EMIT_SAMPLE;
                end
            end
            ST_EMIT_OFF, ST_EMIT_PRIMED, ST_EMIT_SAMPLE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_READ:  cmd.update   = 1'b1;
            ST_ACCUM: cmd.accum    = 1'b1;
            ST_PRIME: cmd.prime    = 1'b1;
            ST_CALC:  cmd.calc     = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_EMIT_OFF:
            begin
                cmd.emit        = stat.out_free;
                cmd.emit_status = STAT_NOT_STARTED;
            end
            ST_EMIT_PRIMED:
            begin
                cmd.emit        = stat.out_free;
                cmd.emit_status = STAT_PRIMED;
            end
            ST_EMIT_SAMPLE:
            begin
                cmd.emit        = stat.out_free;
                cmd.emit_status = STAT_VALID;
            end
            default:  cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/bpls_dp.sv
// Datapath of the load sampler: baselines, work sum, clamp, divider, result register.
`default_nettype none

module bpls_dp #(
    parameter int MAX_ENTRIES = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bpls_pkg::bpls_in_t   in_data,
    input  wire bpls_pkg::bpls_cfg_t  cfg,
    input  wire bpls_pkg::bpls_cmd_t  cmd,
    input  wire logic                 out_stall,
    output bpls_pkg::bpls_stat_t      stat,
    output logic                      out_valid,
    output bpls_pkg::bpls_out_t       out_data
);
    import bpls_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    bpls_in_t               cap_reg;
    logic [MAX_ENTRIES-1:0] base_valid_reg;
    logic [63:0]            delta_reg;
    logic [63:0]            work_sum_reg;
    logic                   primed_reg;
    logic [31:0]            last_core_reg;
    logic [31:0]            total_reg;
    logic [31:0]            work_reg;
    logic [DIV_W-1:0]       rem_reg;
    logic [QUOT_BITS-1:0]   quot_reg;
    logic [CNT_W-1:0]       div_cnt_reg;
    logic                   out_valid_reg;
    bpls_out_t              out_data_reg;

    logic [AW+4:0]    in_idx_wide;
    logic [AW+4:0]    cap_idx_wide;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    cap_addr;
    logic [63:0]      ram_rd;
    logic [63:0]      baseline;
    logic             is_bg;
    logic [31:0]      total_next;
    logic [DIV_W-1:0] div_sub;
    bpls_out_t        out_data_next;

    assign in_idx_wide  = (AW+5)'(in_data.entry_index);
    assign cap_idx_wide = (AW+5)'(cap_reg.entry_index);
    assign in_addr      = in_idx_wide[AW-1:0];
    assign cap_addr     = cap_idx_wide[AW-1:0];

    bpls_ram #(
        .WIDTH (64),
        .DEPTH (MAX_ENTRIES)
    ) u_base_ram (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (cap_addr),
        .wr_data (cap_reg.thread_cycles),
        .rd_en   (cmd.capture),
        .rd_addr (in_addr),
        .rd_data (ram_rd)
    );

    // never-written entries read as zero
    assign baseline = base_valid_reg[cap_addr] ? ram_rd : 64'd0;

    // entries past the mask always count as work
    assign is_bg = (32'(cap_reg.entry_index) < 32'(BG_MASK_BITS))
                   ? cfg.bg_mask[cap_reg.entry_index] : 1'b0;

    assign total_next = cap_reg.core_cycles - last_core_reg;
    assign div_sub    = DIV_W'(total_reg) << div_cnt_reg;

    assign stat.thread_ok = cfg.enabled
                            && (in_data.entry_index < cfg.entry_count)
                            && (32'(in_data.entry_index) < 32'(MAX_ENTRIES));
    assign stat.enabled   = cfg.enabled;
    assign stat.primed    = primed_reg;
    assign stat.div_done  = (div_cnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next.status = cmd.emit_status;
        if (cmd.emit_status == STAT_VALID)
        begin
            out_data_next.total_cycles  = total_reg;
            out_data_next.work_cycles   = work_reg;
            out_data_next.busy_permille = (total_reg == 32'd0) ? '0 : quot_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_valid_reg <= '0;
            work_sum_reg   <= '0;
            primed_reg     <= 1'b0;
            last_core_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                base_valid_reg[cap_addr] <= 1'b1;
            end
            if (cmd.accum && primed_reg && !is_bg)
            begin
                work_sum_reg <= work_sum_reg + delta_reg;
            end
            if (cmd.prime)
            begin
                primed_reg    <= 1'b1;
                last_core_reg <= cap_reg.core_cycles;
                work_sum_reg  <= '0;
            end
            if (cmd.calc)
            begin
                last_core_reg <= cap_reg.core_cycles;
                work_sum_reg  <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_reg <= in_data;
        end
        if (cmd.update)
        begin
            delta_reg <= cap_reg.thread_cycles - baseline;
        end
        if (cmd.calc)
        begin
            total_reg <= total_next;
            work_reg  <= (work_sum_reg > {32'd0, total_next}) ? total_next
                                                               : work_sum_reg[31:0];
        end
        if (cmd.mul)
        begin
            rem_reg     <= DIV_W'(work_reg) * DIV_W'(PERMILLE);
            quot_reg    <= '0;
            div_cnt_reg <= CNT_W'(QUOT_BITS - 1);
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= div_sub)
            begin
                rem_reg               <= rem_reg - div_sub;
                quot_reg[div_cnt_reg] <= 1'b1;
            end
            if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/busy_permille_load_sampler.sv
// Top level of the busy permille load sampler: config registers, sequencer and datapath.
//
// Load monitor for a clock governor. A sample is a run of thread requests
// (req_type 0), each giving the cumulative 64-bit cycle count of one entry,
// closed by an end request (req_type 1) that carries the 32-bit core cycle
// counter. Thread requests update the entry baseline and add the wrapped delta
// to a work sum unless the entry is marked background; they return nothing.
// Each end request returns one result: status 2 while not enabled, status 1
// for the first (priming) sample, otherwise status 0 with the core total, the
// work clamped to it and work*1000/total (0 when the total is 0). Thread
// requests whose entry is out of range, or that arrive while disabled, are
// dropped. Timing: a thread request passes through accept, baseline RAM read
// and accumulate. An end request passes through accept, clamp, multiply, ten
// restoring divider steps producing one quotient bit each and load result, the
// load waiting for a free result register; priming end requests pass through
// accept, prime and load result, disabled ones through accept and load result.
// The divider sets the end-request latency. The result sits in an output register, so
// the next sample's thread requests are taken while a result waits on out_stall.
// Baselines live in a RAM of MAX_ENTRIES words with per-entry valid flops, so there
// is no clearing pass. Config writes are expected only while the block is idle.
`default_nettype none

module busy_permille_load_sampler #(
    parameter int MAX_ENTRIES = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire bpls_pkg::bpls_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output bpls_pkg::bpls_out_t      out_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_wdata
);
    import bpls_pkg::*;

    bpls_cfg_t  cfg_reg;
    bpls_cmd_t  cmd;
    bpls_stat_t stat;

    // configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ENABLED:     cfg_reg.enabled     <= cfg_wdata[0];
                CFG_ENTRY_COUNT: cfg_reg.entry_count <= cfg_wdata[4:0];
                CFG_BG_MASK:     cfg_reg.bg_mask     <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    bpls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_req   (in_data.req_type),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bpls_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/bpls_checker.sv
// Port-level checks of the load sampler results, bound to the top level.
`default_nettype none
`include "busy_permille_load_sampler_macros.svh"

module bpls_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire bpls_pkg::bpls_out_t out_data
);
    import bpls_pkg::*;

    `BPLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `BPLS_ASSERT_NOW(a_non_sample_zero, out_valid && out_data.status != STAT_VALID, out_data.total_cycles == 32'd0 && out_data.work_cycles == 32'd0 && out_data.busy_permille == 10'd0, "non-sample result carries data")
    `BPLS_ASSERT_NOW(a_clamp, out_valid, out_data.work_cycles <= out_data.total_cycles && out_data.busy_permille <= 10'd1000, "work above total or permille above 1000")
    `BPLS_ASSERT_NOW(a_zero_total, out_valid && out_data.total_cycles == 32'd0, out_data.busy_permille == 10'd0, "nonzero permille on zero total")

endmodule

bind busy_permille_load_sampler bpls_checker u_bpls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
